// File: rtl/bpms_pkg.sv
// Shared types, constants and lookup functions for the button press mode selector.
`default_nettype none
package bpms_pkg;

   localparam int COUNT_BITS = 8;
   localparam int CFG_BITS   = 8;
   localparam int CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   localparam logic [CFG_BITS-1:0] ARM_TICKS_RESET       = 8'd6;
   localparam logic [CFG_BITS-1:0] SHORT_MIN_TICKS_RESET = 8'd6;
   localparam logic [CFG_BITS-1:0] SHORT_MAX_TICKS_RESET = 8'd25;
   localparam logic [CFG_BITS-1:0] LONG_MIN_TICKS_RESET  = 8'd70;

   typedef enum logic [1:0] {
      CSR_ARM_TICKS       = 2'd0,
      CSR_SHORT_MIN_TICKS = 2'd1,
      CSR_SHORT_MAX_TICKS = 2'd2,
      CSR_LONG_MIN_TICKS  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_ARMING  = 3'd1,
      PH_WAITREL = 3'd2,
      PH_WAITPR  = 3'd3,
      PH_PRESS   = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   localparam logic [1:0] RING_UPDATE   = 2'd0;
   localparam logic [1:0] RING_RECOVERY = 2'd1;
   localparam logic [1:0] RING_NORMAL   = 2'd2;

   localparam logic [1:0] MODE_NORMAL   = 2'd0;
   localparam logic [1:0] MODE_UPDATE   = 2'd1;
   localparam logic [1:0] MODE_RECOVERY = 2'd2;

   typedef struct packed {
      logic [CFG_BITS-1:0] arm_ticks;
      logic [CFG_BITS-1:0] short_min_ticks;
      logic [CFG_BITS-1:0] short_max_ticks;
      logic [CFG_BITS-1:0] long_min_ticks;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [2:0] selector_phase;
      logic [1:0] ring_index;
      logic       selection_shown;
      logic       decision_valid;
      logic [1:0] decided_mode;
      rgb_type    led;
   } result_type;

   function automatic logic [1:0] ring_mode(input logic [1:0] slot);
      logic [1:0] mode;
      case (slot)
         RING_UPDATE:   mode = MODE_UPDATE;
         RING_RECOVERY: mode = MODE_RECOVERY;
         RING_NORMAL:   mode = MODE_NORMAL;
         default:       mode = MODE_UPDATE;
      endcase
      return mode;
   endfunction

   function automatic rgb_type ring_colour(input logic [1:0] slot);
      rgb_type c;
      case (slot)
         RING_UPDATE:   c = '{red: 8'd16, green: 8'd10, blue: 8'd0};
         RING_RECOVERY: c = '{red: 8'd20, green: 8'd0,  blue: 8'd20};
         RING_NORMAL:   c = '{red: 8'd0,  green: 8'd20, blue: 8'd0};
         default:       c = '{red: 8'd16, green: 8'd10, blue: 8'd0};
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/bpms_channels.sv
// Valid/ready channel interfaces for button samples and selector results.
`default_nettype none
interface bpms_req_if;
   logic valid;
   logic ready;
   logic button_pressed;

   modport source (output valid, output button_pressed, input ready);
   modport sink   (input valid, input button_pressed, output ready);
endinterface

interface bpms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] selector_phase;
   logic [1:0] ring_index;
   logic       selection_shown;
   logic       decision_valid;
   logic [1:0] decided_mode;
   logic [7:0] led_red;
   logic [7:0] led_green;
   logic [7:0] led_blue;

   modport source (output valid, output selector_phase, output ring_index,
                   output selection_shown, output decision_valid, output decided_mode,
                   output led_red, output led_green, output led_blue, input ready);
   modport sink   (input valid, input selector_phase, input ring_index,
                   input selection_shown, input decision_valid, input decided_mode,
                   input led_red, input led_green, input led_blue, output ready);
endinterface
`default_nettype wire

// File: rtl/button_press_mode_selector.sv
// Top level of the button press mode selector.
//
// req_ch carries one sampled button level per tick (button_pressed, 1 = pressed).
// rsp_ch returns one result per sample: phase, ring entry, shown strobe, decision
// and the LED colour of the shown entry, all reflecting the state after the sample.
// csr_wr_en/csr_index/csr_wdata write the four thresholds: 0 arm_ticks,
// 1 short_min_ticks, 2 short_max_ticks, 3 long_min_ticks.
// The result of a sample is registered in the result register, or in the skid entry
// while rsp_ch stalls. Throughput: one sample per cycle while req_ch.ready is high.
// A result register plus one skid entry separate the channels: with rsp_ch stalled,
// one more sample is taken, then req_ch.ready drops until the held result leaves.
// Reset (synchronous, active high) restores the default thresholds, returns the
// selector to its first check with ring entry 0 and normal mode, and empties
// the result buffers.
`default_nettype none
module button_press_mode_selector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bpms_req_if.sink                           req_ch,
   bpms_rsp_if.source                         rsp_ch,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [bpms_pkg::CFG_BITS-1:0] csr_wdata
);
   import bpms_pkg::*;

   cfg_type    cfg;
   result_type step_result;
   result_type out_result;
   logic       req_ready;
   logic       accept;

   assign accept       = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   bpms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpms_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .button_pressed (req_ch.button_pressed),
      .cfg            (cfg),
      .result         (step_result)
   );

   bpms_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ready),
      .in_data   (step_result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_result)
   );

   assign rsp_ch.selector_phase  = out_result.selector_phase;
   assign rsp_ch.ring_index      = out_result.ring_index;
   assign rsp_ch.selection_shown = out_result.selection_shown;
   assign rsp_ch.decision_valid  = out_result.decision_valid;
   assign rsp_ch.decided_mode    = out_result.decided_mode;
   assign rsp_ch.led_red         = out_result.led.red;
   assign rsp_ch.led_green       = out_result.led.green;
   assign rsp_ch.led_blue        = out_result.led.blue;
endmodule
`default_nettype wire

// File: rtl/bpms_csr.sv
// Configuration register file for the press thresholds.
`default_nettype none
module bpms_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [bpms_pkg::CFG_BITS-1:0] csr_wdata,
   output bpms_pkg::cfg_type                  cfg
);
   import bpms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ARM_TICKS:       cfg_in.arm_ticks       = csr_wdata;
            CSR_SHORT_MIN_TICKS: cfg_in.short_min_ticks = csr_wdata;
            CSR_SHORT_MAX_TICKS: cfg_in.short_max_ticks = csr_wdata;
            CSR_LONG_MIN_TICKS:  cfg_in.long_min_ticks  = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_ticks       <= ARM_TICKS_RESET;
         cfg_ff.short_min_ticks <= SHORT_MIN_TICKS_RESET;
         cfg_ff.short_max_ticks <= SHORT_MAX_TICKS_RESET;
         cfg_ff.long_min_ticks  <= LONG_MIN_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// File: rtl/bpms_core.sv
// Selector state registers and the per-sample next-state and result logic.
`default_nettype none
module bpms_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic         button_pressed,
   input  wire bpms_pkg::cfg_type cfg,
   output bpms_pkg::result_type result
);
   import bpms_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [1:0]            ring_ff, ring_in;
   logic [1:0]            mode_ff, mode_in;

   logic [COUNT_BITS-1:0] tick_inc;
   logic [COUNT_BITS-1:0] tick_next;
   logic [CMP_BITS-1:0]   tick_next_ext;
   logic [CMP_BITS-1:0]   tick_cur_ext;
   logic [1:0]            slot_cur;
   logic [1:0]            slot_new;
   logic                  shown;
   logic                  in_window;
   logic                  lit;

   assign tick_inc      = (tick_ff == COUNT_MAX) ? tick_ff : tick_ff + COUNT_ONE;
   assign slot_cur      = (ring_ff == 2'd3) ? RING_UPDATE : ring_ff;
   assign tick_cur_ext  = CMP_BITS'(tick_ff);
   assign tick_next_ext = CMP_BITS'(tick_next);
   assign in_window     = (tick_cur_ext >= CMP_BITS'(cfg.short_min_ticks)) &&
                          (tick_cur_ext <= CMP_BITS'(cfg.short_max_ticks));

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      ring_in   = ring_ff;
      mode_in   = mode_ff;
      shown     = 1'b0;
      tick_next = (phase_ff == PH_FIRST || phase_ff == PH_WAITPR) ? COUNT_ONE : tick_inc;
      case (phase_ff)
         PH_FIRST, PH_ARMING: begin
            if (!button_pressed) begin
               tick_in  = '0;
               mode_in  = MODE_NORMAL;
               phase_in = PH_DONE;
            end else if (tick_next_ext >= CMP_BITS'(cfg.arm_ticks)) begin
               ring_in  = RING_UPDATE;
               tick_in  = '0;
               shown    = 1'b1;
               phase_in = PH_WAITREL;
            end else begin
               tick_in  = tick_next;
               phase_in = PH_ARMING;
            end
         end
         PH_WAITREL: begin
            if (!button_pressed) begin
               phase_in = PH_WAITPR;
            end
         end
         PH_WAITPR, PH_PRESS: begin
            if (button_pressed) begin
               // tick_next is never zero here, so no marker fix-up is needed
               tick_in = tick_next;
               if (tick_next_ext >= CMP_BITS'(cfg.long_min_ticks)) begin
                  mode_in  = ring_mode(slot_cur);
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_PRESS;
               end
            end else if (phase_ff == PH_PRESS) begin
               if (in_window) begin
                  ring_in = (slot_cur == RING_NORMAL) ? RING_UPDATE : slot_cur + 2'd1;
                  shown   = 1'b1;
               end
               phase_in = PH_WAITPR;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   assign slot_new = (ring_in == 2'd3) ? RING_UPDATE : ring_in;
   assign lit      = (phase_in == PH_WAITREL) || (phase_in == PH_WAITPR) ||
                     (phase_in == PH_PRESS) || ((phase_in == PH_DONE) && (tick_in != '0));

   always_comb begin
      result.selector_phase  = phase_in;
      result.ring_index      = ring_in;
      result.selection_shown = shown;
      result.decision_valid  = (phase_in == PH_DONE);
      result.decided_mode    = (phase_in == PH_DONE) ? mode_in : MODE_NORMAL;
      result.led             = lit ? ring_colour(slot_new) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         tick_ff  <= '0;
         ring_ff  <= RING_UPDATE;
         mode_ff  <= MODE_NORMAL;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         ring_ff  <= ring_in;
         mode_ff  <= mode_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/bpms_skid.sv
// Result register with a skid stage so one more sample can be taken while the sink stalls.
`default_nettype none
module bpms_skid (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire bpms_pkg::result_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output bpms_pkg::result_type out_data
);
   import bpms_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       push;
   logic       take;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign take     = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = in_data;
         end
      end else if (!main_valid_ff) begin
         main_valid_in = push;
         main_in       = in_data;
      end else if (push) begin
         // main still waiting: park the new result behind it
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the button press mode selector: random press sequences vs a predictor.
`default_nettype none
module testbench;
   import bpms_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int STALL_LIMIT   = 1000;
   localparam int TOTAL_SAMPLES = 1500;
   localparam int REPORT_LIMIT  = 10;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [1:0]          csr_index   = CSR_ARM_TICKS;
   logic [CFG_BITS-1:0] csr_wdata   = '0;
   logic                req_valid   = 1'b0;
   logic                req_pressed = 1'b0;
   logic                rsp_ready   = 1'b0;
   logic                req_taken   = 1'b0;
   logic                steady      = 1'b0;

   int samples_queued = 0;
   int samples_taken  = 0;
   int results_seen   = 0;
   int error_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int idle_cycles    = 0;

   // predictor state and its copy of the thresholds
   cfg_type               cfg_model;
   phase_type             sel_phase;
   logic [COUNT_BITS-1:0] press_ticks;
   logic [1:0]            ring_pos;
   logic [1:0]            chosen_mode;

   logic       pending_samples[$];
   result_type expected_results[$];

   bpms_req_if req_ch ();
   bpms_rsp_if rsp_ch ();

   assign req_ch.valid          = req_valid;
   assign req_ch.button_pressed = req_pressed;
   assign rsp_ch.ready          = rsp_ready;

   button_press_mode_selector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic result_type predict_selector(input logic pressed);
      result_type r;
      logic       shown;
      logic       lit;
      logic [1:0] slot;
      shown = 1'b0;
      slot  = (ring_pos > RING_NORMAL) ? RING_UPDATE : ring_pos;
      case (sel_phase)
         PH_FIRST, PH_ARMING: begin
            if (!pressed) begin
               // early normal decision, no colour shown afterwards
               press_ticks = '0;
               chosen_mode = MODE_NORMAL;
               sel_phase   = PH_DONE;
            end else begin
               if (sel_phase == PH_FIRST) press_ticks = COUNT_ONE;
               else if (press_ticks != COUNT_MAX) press_ticks++;
               if (press_ticks >= cfg_model.arm_ticks) begin
                  ring_pos    = RING_UPDATE;
                  press_ticks = '0;
                  shown       = 1'b1;
                  sel_phase   = PH_WAITREL;
               end else begin
                  sel_phase = PH_ARMING;
               end
            end
         end
         PH_WAITREL: begin
            if (!pressed) sel_phase = PH_WAITPR;
         end
         PH_WAITPR, PH_PRESS: begin
            if (pressed) begin
               if (sel_phase == PH_WAITPR) press_ticks = COUNT_ONE;
               else if (press_ticks != COUNT_MAX) press_ticks++;
               if (press_ticks >= cfg_model.long_min_ticks) begin
                  case (slot)
                     RING_RECOVERY: chosen_mode = MODE_RECOVERY;
                     RING_NORMAL:   chosen_mode = MODE_NORMAL;
                     default:       chosen_mode = MODE_UPDATE;
                  endcase
                  if (press_ticks == '0) press_ticks = COUNT_ONE;
                  sel_phase = PH_DONE;
               end else begin
                  sel_phase = PH_PRESS;
               end
            end else if (sel_phase == PH_PRESS) begin
               if (press_ticks >= cfg_model.short_min_ticks &&
                   press_ticks <= cfg_model.short_max_ticks) begin
                  ring_pos = (slot == RING_NORMAL) ? RING_UPDATE : slot + 2'd1;
                  shown    = 1'b1;
               end
               sel_phase = PH_WAITPR;
            end
         end
         default: sel_phase = PH_DONE;
      endcase

      slot = (ring_pos > RING_NORMAL) ? RING_UPDATE : ring_pos;
      lit  = sel_phase == PH_WAITREL || sel_phase == PH_WAITPR || sel_phase == PH_PRESS ||
             (sel_phase == PH_DONE && press_ticks != '0);
      r = '0;
      r.selector_phase  = sel_phase;
      r.ring_index      = ring_pos;
      r.selection_shown = shown;
      r.decision_valid  = (sel_phase == PH_DONE);
      r.decided_mode    = (sel_phase == PH_DONE) ? chosen_mode : MODE_NORMAL;
      if (lit) begin
         case (slot)
            RING_RECOVERY: r.led = '{red: 8'd20, green: 8'd0,  blue: 8'd20};
            RING_NORMAL:   r.led = '{red: 8'd0,  green: 8'd20, blue: 8'd0};
            default:       r.led = '{red: 8'd16, green: 8'd10, blue: 8'd0};
         endcase
      end
      return r;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("phase %0d ring %0d shown %0b decided %0b mode %0d rgb %0d/%0d/%0d",
                       r.selector_phase, r.ring_index, r.selection_shown, r.decision_valid,
                       r.decided_mode, r.led.red, r.led.green, r.led.blue);
   endfunction

   // sample driver: next button level goes out on the falling edge
   always @(negedge clock) begin : sample_driver
      if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_samples.size() > 0) begin
            req_valid   <= 1'b1;
            req_pressed <= pending_samples.pop_front();
            send_gap     = draw_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_sink
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = draw_gap();
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_selector(req_ch.button_pressed));
            samples_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.selector_phase  = rsp_ch.selector_phase;
            got.ring_index      = rsp_ch.ring_index;
            got.selection_shown = rsp_ch.selection_shown;
            got.decision_valid  = rsp_ch.decision_valid;
            got.decided_mode    = rsp_ch.decided_mode;
            got.led.red         = rsp_ch.led_red;
            got.led.green       = rsp_ch.led_green;
            got.led.blue        = rsp_ch.led_blue;
            if (expected_results.size() == 0) begin
               if (error_count < REPORT_LIMIT)
                  $display("result %0d with no sample pending: %s", results_seen, describe(got));
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (error_count < REPORT_LIMIT)
                     $display("result %0d mismatch\n  expected %s\n  actual   %s",
                              results_seen, describe(want), describe(got));
                  error_count++;
               end
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic add_sample(input logic level);
      pending_samples.push_back(level);
      samples_queued++;
   endtask

   task automatic add_press(input int len, input int gap);
      repeat (len) add_sample(1'b1);
      repeat (gap) add_sample(1'b0);
   endtask

   // random levels, pressed runs kept short of the execute threshold
   task automatic add_noise(input int count);
      int   cap;
      int   run;
      logic level;
      cap = int'(cfg_model.long_min_ticks) - 1;
      run = 0;
      repeat (count) begin
         level = 1'($urandom_range(0, 1));
         if (level && run >= cap) level = 1'b0;
         run = level ? run + 1 : 0;
         add_sample(level);
      end
      add_sample(1'b0);
   endtask

   function automatic int pick_press_len();
      int cap;
      int lo;
      int hi;
      int len;
      cap = int'(cfg_model.long_min_ticks) - 1;
      lo  = int'(cfg_model.short_min_ticks);
      hi  = int'(cfg_model.short_max_ticks);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: len = (lo <= hi) ? $urandom_range(lo, (hi > lo + 30) ? lo + 30 : hi)
                                      : $urandom_range(1, 12);
         4:          len = lo - 1;
         5:          len = lo;
         6:          len = hi;
         7:          len = hi + 1;
         8:          len = $urandom_range(1, 5);
         default:    len = ($urandom_range(0, 4) == 0) ? cap : $urandom_range(1, 20);
      endcase
      if (len > cap) len = cap;
      if (len < 1) len = 1;
      return len;
   endfunction

   function automatic int pick_release();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 1;
   endfunction

   task automatic write_threshold(input csr_index_type idx, input logic [CFG_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_ARM_TICKS:       cfg_model.arm_ticks       = value;
         CSR_SHORT_MIN_TICKS: cfg_model.short_min_ticks = value;
         CSR_SHORT_MAX_TICKS: cfg_model.short_max_ticks = value;
         default:             cfg_model.long_min_ticks  = value;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic apply_thresholds(input int arm, input int lo, input int hi, input int exec);
      write_threshold(CSR_ARM_TICKS, CFG_BITS'(arm));
      write_threshold(CSR_SHORT_MIN_TICKS, CFG_BITS'(lo));
      write_threshold(CSR_SHORT_MAX_TICKS, CFG_BITS'(hi));
      write_threshold(CSR_LONG_MIN_TICKS, CFG_BITS'(exec));
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (samples_taken != samples_queued || expected_results.size() != 0);
   endtask

   initial begin : stimulus
      int arm_len;
      int lo_ticks;
      int hi_ticks;
      int exec_ticks;

      cfg_model = '{arm_ticks:       ARM_TICKS_RESET,
                    short_min_ticks: SHORT_MIN_TICKS_RESET,
                    short_max_ticks: SHORT_MAX_TICKS_RESET,
                    long_min_ticks:  LONG_MIN_TICKS_RESET};
      sel_phase   = PH_FIRST;
      press_ticks = '0;
      ring_pos    = RING_UPDATE;
      chosen_mode = MODE_NORMAL;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // arming: one threshold per run, extremes favored
      case ($urandom_range(0, 3))
         0:       arm_len = 1;
         1:       arm_len = 255;
         default: arm_len = $urandom_range(2, 40);
      endcase
      apply_thresholds(arm_len, 2, 4, 255);
      @(posedge clock);
      repeat (arm_len + $urandom_range(0, 3)) add_sample(1'b1);
      add_sample(1'b0);
      // window edges: bounce, min, max, above max, inside
      add_press(1, 1);
      add_press(2, 1);
      add_press(4, 2);
      add_press(5, 1);
      add_press(3, 1);

      while (samples_queued < TOTAL_SAMPLES - 100) begin
         wait_idle();
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: begin lo_ticks = 0; hi_ticks = 255; end
            1: begin lo_ticks = $urandom_range(1, 10); hi_ticks = lo_ticks; end
            2: begin
               // empty window: nothing advances the ring
               if ($urandom_range(0, 1) == 1) begin
                  lo_ticks = 255;
                  hi_ticks = 0;
               end else begin
                  lo_ticks = $urandom_range(5, 20);
                  hi_ticks = lo_ticks - $urandom_range(1, 4);
               end
            end
            3: begin
               lo_ticks = $urandom_range(1, 12);
               hi_ticks = lo_ticks + $urandom_range(0, 15);
            end
            4: begin lo_ticks = 0; hi_ticks = 0; end
            default: begin lo_ticks = $urandom_range(1, 10); hi_ticks = 255; end
         endcase
         case ($urandom_range(0, 2))
            0:       exec_ticks = 255;
            1:       exec_ticks = $urandom_range((hi_ticks < 253) ? hi_ticks + 2 : 255, 255);
            default: exec_ticks = $urandom_range(2, 60);
         endcase
         apply_thresholds($urandom_range(1, 255), lo_ticks, hi_ticks, exec_ticks);
         @(posedge clock);
         repeat ($urandom_range(8, 20)) begin
            if ($urandom_range(0, 9) == 0) add_noise($urandom_range(4, 16));
            else add_press(pick_press_len(), pick_release());
         end
      end

      // final press executes the shown entry, then the decision must hold
      wait_idle();
      steady   = 1'b0;
      lo_ticks = $urandom_range(1, 12);
      hi_ticks = lo_ticks + $urandom_range(0, 15);
      case ($urandom_range(0, 2))
         0:       exec_ticks = 1;
         1:       exec_ticks = 255;
         default: exec_ticks = $urandom_range(2, 80);
      endcase
      apply_thresholds($urandom_range(1, 255), lo_ticks, hi_ticks, exec_ticks);
      @(posedge clock);
      if (exec_ticks > 1) begin
         repeat ($urandom_range(2, 6)) add_press(pick_press_len(), pick_release());
      end
      repeat (exec_ticks) add_sample(1'b1);
      repeat ($urandom_range(20, 40)) add_sample(1'($urandom_range(0, 1)));

      wait_idle();
      repeat (4) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
